FILE: hdl/nvrgb_pkg.sv
// Shared types and constants for the NV12/NV21 to RGB block converter.
package nvrgb_pkg;

  // Field and bus widths
  localparam int BYTE_W = 8;
  localparam int IN_FIELDS = 6;
  localparam int OUT_FIELDS = 12;
  localparam int IN_DATA_W = IN_FIELDS * BYTE_W;
  localparam int OUT_DATA_W = OUT_FIELDS * BYTE_W;
  localparam int PIXELS = 4;

  // Working width of the Q7 sums (covers -32960 .. 68441)
  localparam int TERM_W = 18;
  typedef logic signed [TERM_W-1:0] term_t;

  // Q7 coefficients and offsets (BT.601)
  localparam term_t COEF_V_TO_R = 18'sd204;
  localparam term_t COEF_V_TO_G = -18'sd104;
  localparam term_t COEF_U_TO_G = -18'sd50;
  localparam term_t COEF_U_TO_B = 18'sd258;
  localparam term_t Q7_HALF = 18'sd64;
  localparam term_t Q7_MAX = 18'sd32640;
  localparam int Q7_SHIFT = 7;
  localparam logic [15:0] COEF_Y = 16'd149;
  localparam logic [7:0] LUMA_OFFSET = 8'd16;
  localparam logic signed [8:0] CHROMA_MID = 9'sd128;

  // Chroma order register values
  localparam logic ORDER_NV12 = 1'b0;
  localparam logic ORDER_NV21 = 1'b1;

  // Chroma contributions shared by the four pixels of a block
  typedef struct packed {
    term_t red;
    term_t green;
    term_t blue;
  } chroma_terms_t;

  // One output pixel
  typedef struct packed {
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] red;
  } rgb_t;

endpackage

FILE: hdl/nvrgb_chroma.sv
// Chroma byte ordering and the three chroma terms shared by a 2x2 block.
module nvrgb_chroma
  import nvrgb_pkg::*;
(
  input  logic [BYTE_W-1:0] chroma_first,
  input  logic [BYTE_W-1:0] chroma_second,
  input  logic              chroma_order,
  output chroma_terms_t     terms
);

  logic [BYTE_W-1:0] u_raw;
  logic [BYTE_W-1:0] v_raw;
  logic signed [8:0] u;
  logic signed [8:0] v;

  // NV12 carries U first, NV21 carries V first
  always_comb begin
    if (chroma_order == ORDER_NV21) begin
      v_raw = chroma_first;
      u_raw = chroma_second;
    end else begin
      u_raw = chroma_first;
      v_raw = chroma_second;
    end
  end

  // Center chroma around zero
  assign u = $signed({1'b0, u_raw}) - CHROMA_MID;
  assign v = $signed({1'b0, v_raw}) - CHROMA_MID;

  // Rounding half folded into each term; green adds it once
  assign terms.red   = term_t'(v) * COEF_V_TO_R + Q7_HALF;
  assign terms.green = term_t'(v) * COEF_V_TO_G + term_t'(u) * COEF_U_TO_G + Q7_HALF;
  assign terms.blue  = term_t'(u) * COEF_U_TO_B + Q7_HALF;

endmodule

FILE: hdl/nvrgb_pixel.sv
// Luma scaling, chroma add and Q7 clamp for one pixel.
module nvrgb_pixel
  import nvrgb_pkg::*;
(
  input  logic [BYTE_W-1:0] luma,
  input  chroma_terms_t     terms,
  output rgb_t              rgb
);

  logic [BYTE_W-1:0] y_off;
  logic [15:0]       yt;
  term_t             yt_s;

  // Clamp to 0..255 in Q7, then drop the fraction
  function automatic logic [BYTE_W-1:0] clamp_q7(input term_t sum);
    logic [BYTE_W-1:0] res;
    if (sum < 0) begin
      res = '0;
    end else if (sum > Q7_MAX) begin
      res = '1;
    end else begin
      res = sum[Q7_SHIFT +: BYTE_W];
    end
    return res;
  endfunction

  // Offset luma floored at zero, then scaled
  assign y_off = (luma < LUMA_OFFSET) ? '0 : luma - LUMA_OFFSET;
  assign yt    = {8'd0, y_off} * COEF_Y;
  assign yt_s  = $signed({2'b00, yt});

  assign rgb.red   = clamp_q7(yt_s + terms.red);
  assign rgb.green = clamp_q7(yt_s + terms.green);
  assign rgb.blue  = clamp_q7(yt_s + terms.blue);

endmodule

FILE: hdl/nv12_to_rgb_block.sv
// Top level: NV12/NV21 2x2 block to twelve RGB bytes, BT.601 Q7 arithmetic.
//
//  channel | dir | contents
//  --------+-----+---------------------------------------------------------
//  s_*     | in  | one 2x2 luma block plus its interleaved chroma pair
//  m_*     | out | R,G,B for the four pixels of the block
//  cfg_*   | in  | chroma_order: 0 = U first (NV12), 1 = V first (NV21)
//
//  One block per cycle sustained while m_tready is high. A request lands in
//  the input register, the conversion runs in one pass of logic and lands in
//  the output register. A stalled output register holds its request while the
//  input register still takes one more; s_tready drops only when both are
//  full. Reset clears both valid flags and sets chroma_order to NV12.
module nv12_to_rgb_block
  import nvrgb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // cfg: write enable and chroma_order bit
  input  logic                  cfg_we,
  input  logic                  cfg_wdata,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // s_tdata, low to high: luma_top_left, luma_top_right, luma_bottom_left,
  // luma_bottom_right, chroma_first, chroma_second
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // m_tdata, low to high: red/green/blue_top_left, red/green/blue_top_right,
  // red/green/blue_bottom_left, red/green/blue_bottom_right
  output logic [OUT_DATA_W-1:0] m_tdata
);

  logic                  chroma_order;
  logic                  s1_valid;
  logic [IN_DATA_W-1:0]  s1_data;
  logic                  s1_adv;
  chroma_terms_t         terms;
  rgb_t [PIXELS-1:0]     rgb;
  logic [OUT_DATA_W-1:0] m_tdata_next;

  // Handshake: input register moves on when the output register is free
  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_adv;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      chroma_order <= ORDER_NV12;
    end else if (cfg_we) begin
      chroma_order <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_data <= s_tdata;
    end
  end

  // Chroma terms shared by the block
  nvrgb_chroma u_chroma (
    .chroma_first  (s1_data[4*BYTE_W +: BYTE_W]),
    .chroma_second (s1_data[5*BYTE_W +: BYTE_W]),
    .chroma_order  (chroma_order),
    .terms         (terms)
  );

  // One converter per pixel
  for (genvar p = 0; p < PIXELS; p++) begin : g_pix
    nvrgb_pixel u_pixel (
      .luma  (s1_data[p*BYTE_W +: BYTE_W]),
      .terms (terms),
      .rgb   (rgb[p])
    );
    assign m_tdata_next[p*3*BYTE_W +: 3*BYTE_W] = {rgb[p].blue, rgb[p].green, rgb[p].red};
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_tdata <= m_tdata_next;
    end
  end

  // A request leaving the input register shows up at the output
  a_adv_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> m_tvalid)
    else $error("converted request did not reach the output register");

  // Backpressure only when the input register is full and cannot move
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s1_valid && m_tvalid && !m_tready))
    else $error("s_tready low without a full pipeline");

  // A blocked request stays in the input register
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_data)))
    else $error("blocked request lost from the input register");

  // An accepted request occupies the input register next cycle
  a_accept_s1: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> s1_valid)
    else $error("accepted request not held");

endmodule
